### rtl/core/tsrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsrt_pkg;

	// table size and the width of a count that can hold it
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SEQ_W = 32;

	typedef enum logic [3:0] {
		OP_APPEND  = 4'd0,
		OP_INSERT  = 4'd1,
		OP_COVERED = 4'd2,
		OP_TOTAL   = 4'd3,
		OP_OVERLAP = 4'd4,
		OP_SPAN    = 4'd5,
		OP_CHAIN   = 4'd6,
		OP_DELBEF  = 4'd7,
		OP_CLEAR   = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	// one stored byte range [rbeg, rend)
	typedef struct packed {
		logic [SEQ_W-1:0] rbeg;
		logic [SEQ_W-1:0] rend;
	} entry_t;

	// wrapping sequence order: a before b
	function automatic logic seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return d[SEQ_W-1];
	endfunction

endpackage
`default_nettype wire

### rtl/core/tsrt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tsrt_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [31:0] seq_a;
	logic [31:0] seq_b;

	modport source (output valid, output opcode, output seq_a, output seq_b, input ready);
	modport sink   (input valid, input opcode, input seq_a, input seq_b, output ready);
endinterface

interface tsrt_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] byte_count;
	logic [31:0] span_low;
	logic [31:0] span_high;
	logic [31:0] next_seq;
	logic        table_full;

	modport source (output valid, output hit, output byte_count, output span_low,
		output span_high, output next_seq, output table_full, input ready);
	modport sink   (input valid, input hit, input byte_count, input span_low,
		input span_high, input next_seq, input table_full, output ready);
endinterface
`default_nettype wire

### rtl/core/tsrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One slot of the range queue: takes its upper neighbour on a pop,
// or the pushed word when it is the write slot.
module tsrt_cell (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire logic            load,
	input  tsrt_pkg::entry_t     nbr,
	input  tsrt_pkg::entry_t     wdata,
	output tsrt_pkg::entry_t     q
);

	tsrt_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= wdata;
		end else if (shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

### rtl/core/tcp_seq_range_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered table of up to DEPTH TCP byte ranges kept in a row of cells that
// works as a queue: each scan step takes the oldest range out of cell 0 and
// writes it back at the tail (or drops it), or writes a new range at the
// tail ahead of it, so one pass visits every stored range. Append, clear and
// unknown opcodes finish without a pass; covered, total, overlap, span and
// delete-before make one pass; insert makes one pass, plus a step that
// writes the new range when a range beginning at the new end is found; chain
// delete does one pass per removed range plus a final pass. One word is
// processed at a time; a new word is taken while the last result waits.
module tcp_seq_range_table (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tsrt_in_if.sink    in_ch,
	tsrt_out_if.source out_ch
);

	localparam int CW = tsrt_pkg::CNT_W;
	localparam int N  = tsrt_pkg::DEPTH;

	tsrt_pkg::state_t  state_q, state_d;
	tsrt_pkg::opcode_t op_q;
	logic [31:0]       a_q, b_q;
	logic [CW-1:0]     cnt_q, cnt_d, n_q, n_d, idx_q, idx_d;
	logic              flag_q, flag_d, res_q, res_d, full_q, full_d;
	logic [31:0]       acc_q, acc_d, lo_q, lo_d, hi_q, hi_d, nxt_q, nxt_d;

	logic              ovalid_q;
	logic              o_hit_q, o_full_q;
	logic [31:0]       o_cnt_q, o_lo_q, o_hi_q, o_nxt_q;
	logic              oload;

	logic              pop, push;
	tsrt_pkg::entry_t  wdata, head;
	logic [CW-1:0]     wpos;
	tsrt_pkg::entry_t  cq [N];
	tsrt_pkg::entry_t  nbr [N];

	// cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == N - 1) begin : g_last
			assign nbr[i] = '0;
		end else begin : g_mid
			assign nbr[i] = cq[i+1];
		end
		tsrt_cell u_cell (
			.clk   (clk),
			.shift (pop),
			.load  (push && (wpos == CW'(i))),
			.nbr   (nbr[i]),
			.wdata (wdata),
			.q     (cq[i])
		);
	end

	assign head = cq[0];
	assign wpos = cnt_q - CW'(pop);

	// sequencer
	always_comb begin
		logic        bb, ba, rem;
		logic [31:0] ov_hi, ov_lo;
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		idx_d   = idx_q;
		flag_d  = flag_q;
		res_d   = res_q;
		full_d  = full_q;
		acc_d   = acc_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		nxt_d   = nxt_q;
		pop     = 1'b0;
		push    = 1'b0;
		wdata   = head;
		oload   = 1'b0;
		bb      = tsrt_pkg::seq_before(head.rbeg, b_q);
		ba      = tsrt_pkg::seq_before(a_q, head.rend);
		ov_hi   = tsrt_pkg::seq_before(head.rend, b_q) ? head.rend : b_q;
		ov_lo   = tsrt_pkg::seq_before(a_q, head.rbeg) ? head.rbeg : a_q;
		rem     = !tsrt_pkg::seq_before(a_q, head.rend);
		unique case (state_q)
			tsrt_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = tsrt_pkg::ST_SCAN;
					n_d     = cnt_q;
					idx_d   = '0;
					flag_d  = 1'b0;
					res_d   = 1'b0;
					full_d  = 1'b0;
					acc_d   = '0;
					lo_d    = in_ch.seq_a;
					hi_d    = in_ch.seq_a;
					nxt_d   = in_ch.seq_a;
				end
			end
			tsrt_pkg::ST_SCAN: begin
				unique case (op_q)
					tsrt_pkg::OP_APPEND: begin
						state_d = tsrt_pkg::ST_FIN;
						if (cnt_q == CW'(N)) begin
							full_d = 1'b1;
						end else begin
							push  = 1'b1;
							wdata = '{rbeg: a_q, rend: b_q};
						end
					end
					tsrt_pkg::OP_INSERT: begin
						// fullness judged on the count at the start of the word
						if (n_q == CW'(N)) begin
							full_d  = 1'b1;
							state_d = tsrt_pkg::ST_FIN;
						end else if (idx_q == n_q) begin
							state_d = tsrt_pkg::ST_FIN;
							if (!flag_q) begin
								push  = 1'b1;
								wdata = '{rbeg: a_q, rend: b_q};
							end
						end else if (!flag_q && head.rbeg == b_q) begin
							push   = 1'b1;
							wdata  = '{rbeg: a_q, rend: b_q};
							flag_d = 1'b1;
						end else begin
							pop   = 1'b1;
							push  = 1'b1;
							idx_d = idx_q + CW'(1);
						end
					end
					tsrt_pkg::OP_COVERED, tsrt_pkg::OP_TOTAL, tsrt_pkg::OP_OVERLAP,
					tsrt_pkg::OP_SPAN: begin
						if (idx_q == n_q) begin
							state_d = tsrt_pkg::ST_FIN;
						end else begin
							pop   = 1'b1;
							push  = 1'b1;
							idx_d = idx_q + CW'(1);
							// later trigger wins: same as a newest-first scan
							if (op_q == tsrt_pkg::OP_COVERED) begin
								if (!tsrt_pkg::seq_before(a_q, head.rbeg) && ba) begin
									res_d = 1'b1;
								end else if (tsrt_pkg::seq_before(a_q, head.rbeg)) begin
									res_d = 1'b0;
								end
							end else if (op_q == tsrt_pkg::OP_TOTAL) begin
								acc_d = acc_q + (head.rend - head.rbeg);
							end else if (op_q == tsrt_pkg::OP_OVERLAP) begin
								if (bb && ba) begin
									acc_d = acc_q + (ov_hi - ov_lo);
								end
							end else begin
								if (tsrt_pkg::seq_before(head.rbeg, lo_q)) begin
									lo_d = head.rbeg;
								end
								if (tsrt_pkg::seq_before(hi_q, head.rend)) begin
									hi_d = head.rend;
								end
							end
						end
					end
					tsrt_pkg::OP_CHAIN: begin
						if (idx_q == n_q) begin
							// restart after a removal, else finished
							if (flag_q) begin
								n_d    = cnt_q;
								idx_d  = '0;
								flag_d = 1'b0;
							end else begin
								state_d = tsrt_pkg::ST_FIN;
							end
						end else begin
							pop   = 1'b1;
							idx_d = idx_q + CW'(1);
							if (!flag_q && head.rbeg == nxt_q) begin
								nxt_d  = head.rend;
								flag_d = 1'b1;
								cnt_d  = cnt_q - CW'(1);
							end else begin
								push = 1'b1;
							end
						end
					end
					tsrt_pkg::OP_DELBEF: begin
						if (idx_q == n_q) begin
							state_d = tsrt_pkg::ST_FIN;
						end else begin
							pop   = 1'b1;
							idx_d = idx_q + CW'(1);
							if (!flag_q && rem) begin
								cnt_d = cnt_q - CW'(1);
							end else begin
								push = 1'b1;
							end
							if (!tsrt_pkg::seq_before(head.rbeg, a_q)) begin
								flag_d = 1'b1;
							end
						end
					end
					tsrt_pkg::OP_CLEAR: begin
						cnt_d   = '0;
						state_d = tsrt_pkg::ST_FIN;
					end
					default: begin
						state_d = tsrt_pkg::ST_FIN;
					end
				endcase
				// only a push without a pop grows the table
				if (op_q == tsrt_pkg::OP_APPEND || op_q == tsrt_pkg::OP_INSERT) begin
					if (push && !pop) begin
						cnt_d = cnt_q + CW'(1);
					end
				end
			end
			tsrt_pkg::ST_FIN: begin
				if (!ovalid_q || out_ch.ready) begin
					oload   = 1'b1;
					state_d = tsrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsrt_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ch.ready = (state_q == tsrt_pkg::ST_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tsrt_pkg::ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (oload) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == tsrt_pkg::ST_IDLE && in_ch.valid) begin
			op_q <= tsrt_pkg::opcode_t'(in_ch.opcode);
			a_q  <= in_ch.seq_a;
			b_q  <= in_ch.seq_b;
		end
		n_q    <= n_d;
		idx_q  <= idx_d;
		flag_q <= flag_d;
		res_q  <= res_d;
		full_q <= full_d;
		acc_q  <= acc_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		nxt_q  <= nxt_d;
	end

	// result register; fields not produced by the opcode read zero
	always_ff @(posedge clk) begin
		if (oload) begin
			o_hit_q  <= (op_q == tsrt_pkg::OP_COVERED) && res_q;
			o_full_q <= full_q;
			o_cnt_q  <= (op_q == tsrt_pkg::OP_TOTAL || op_q == tsrt_pkg::OP_OVERLAP) ? acc_q :
				(op_q == tsrt_pkg::OP_SPAN) ? (hi_q - lo_q) : '0;
			o_lo_q   <= (op_q == tsrt_pkg::OP_SPAN) ? lo_q : '0;
			o_hi_q   <= (op_q == tsrt_pkg::OP_SPAN) ? hi_q : '0;
			o_nxt_q  <= (op_q == tsrt_pkg::OP_CHAIN) ? nxt_q : '0;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.hit        = o_hit_q;
	assign out_ch.byte_count = o_cnt_q;
	assign out_ch.span_low   = o_lo_q;
	assign out_ch.span_high  = o_hi_q;
	assign out_ch.next_seq   = o_nxt_q;
	assign out_ch.table_full = o_full_q;

endmodule
`default_nettype wire

### bench/tcp_seq_range_table_tb.sv
`timescale 1ns / 1ps
module tcp_seq_range_table_tb;

	typedef bit bool_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] byte_count;
		logic [31:0] span_low;
		logic [31:0] span_high;
		logic [31:0] next_seq;
		logic        table_full;
	} answer_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   hold_off;

	tsrt_in_if  in_ch ();
	tsrt_out_if out_ch ();

	tcp_seq_range_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// shadow copy of the range table
	logic [31:0] tbl_beg [tsrt_pkg::DEPTH];
	logic [31:0] tbl_end [tsrt_pkg::DEPTH];
	int          tbl_cnt;
	answer_t     answers_due [$];

	function automatic logic wrap_before(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic void tbl_put(int pos, logic [31:0] b, logic [31:0] e);
		for (int i = tbl_cnt; i > pos; i--) begin
			tbl_beg[i] = tbl_beg[i-1];
			tbl_end[i] = tbl_end[i-1];
		end
		tbl_beg[pos] = b;
		tbl_end[pos] = e;
		tbl_cnt++;
	endfunction

	function automatic void tbl_remove(int pos);
		for (int i = pos; i + 1 < tbl_cnt; i++) begin
			tbl_beg[i] = tbl_beg[i+1];
			tbl_end[i] = tbl_end[i+1];
		end
		tbl_cnt--;
	endfunction

	// works out the answer to one word and updates the shadow table
	function automatic answer_t table_answer(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		answer_t r;
		int      pos;
		bool_t   found;
		logic    stop;
		int      i;
		r = '0;
		case (op)
			tsrt_pkg::OP_APPEND: begin
				if (tbl_cnt >= tsrt_pkg::DEPTH) r.table_full = 1'b1;
				else tbl_put(tbl_cnt, a, b);
			end
			tsrt_pkg::OP_INSERT: begin
				if (tbl_cnt >= tsrt_pkg::DEPTH) r.table_full = 1'b1;
				else begin
					pos = tbl_cnt;
					for (int k = 0; k < tbl_cnt; k++)
						if (tbl_beg[k] == b) begin
							pos = k;
							break;
						end
					tbl_put(pos, a, b);
				end
			end
			tsrt_pkg::OP_COVERED: begin
				for (int k = tbl_cnt - 1; k >= 0; k--) begin
					if (!wrap_before(a, tbl_beg[k]) && wrap_before(a, tbl_end[k])) begin
						r.hit = 1'b1;
						break;
					end
					if (wrap_before(a, tbl_beg[k])) break;
				end
			end
			tsrt_pkg::OP_TOTAL: begin
				for (int k = 0; k < tbl_cnt; k++)
					r.byte_count += tbl_end[k] - tbl_beg[k];
			end
			tsrt_pkg::OP_OVERLAP: begin
				for (int k = 0; k < tbl_cnt; k++) begin
					if (!wrap_before(tbl_beg[k], b) || !wrap_before(a, tbl_end[k])) continue;
					r.byte_count += (wrap_before(tbl_end[k], b) ? tbl_end[k] : b)
						- (wrap_before(a, tbl_beg[k]) ? tbl_beg[k] : a);
				end
			end
			tsrt_pkg::OP_SPAN: begin
				r.span_low  = a;
				r.span_high = a;
				for (int k = 0; k < tbl_cnt; k++) begin
					if (wrap_before(tbl_beg[k], r.span_low)) r.span_low = tbl_beg[k];
					if (wrap_before(r.span_high, tbl_end[k])) r.span_high = tbl_end[k];
				end
				r.byte_count = r.span_high - r.span_low;
			end
			tsrt_pkg::OP_CHAIN: begin
				r.next_seq = a;
				found = 1'b1;
				while (found) begin
					found = 1'b0;
					for (int k = 0; k < tbl_cnt; k++)
						if (tbl_beg[k] == r.next_seq) begin
							r.next_seq = tbl_end[k];
							tbl_remove(k);
							found = 1'b1;
							break;
						end
				end
			end
			tsrt_pkg::OP_DELBEF: begin
				i = 0;
				while (i < tbl_cnt) begin
					stop = !wrap_before(tbl_beg[i], a);
					if (!wrap_before(a, tbl_end[i])) tbl_remove(i);
					else i++;
					if (stop) break;
				end
			end
			tsrt_pkg::OP_CLEAR: tbl_cnt = 0;
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sends one word after a random gap; prediction is made on acceptance
	task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.opcode <= op;
		in_ch.seq_a  <= a;
		in_ch.seq_b  <= b;
		do @(posedge clk); while (!in_ch.ready);
		answers_due.push_back(table_answer(op, a, b));
	endtask

	// result checker and receiver stalls
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				stall    = hold_off;
				hold_off = 0;
			end else begin
				stall = $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0) stall = 0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			check_word();
		end
	end

	task automatic check_word();
		answer_t got, want;
		got = '{out_ch.hit, out_ch.byte_count, out_ch.span_low, out_ch.span_high,
			out_ch.next_seq, out_ch.table_full};
		if (answers_due.size() == 0) begin
			$display("%0t: unexpected word, actual %h", $time, got);
			errors++;
		end else begin
			want = answers_due.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit expected %h actual %h", $time, want.hit, got.hit);
				errors++;
			end
			if (got.byte_count !== want.byte_count) begin
				$display("%0t: byte_count expected %h actual %h", $time,
					want.byte_count, got.byte_count);
				errors++;
			end
			if (got.span_low !== want.span_low) begin
				$display("%0t: span_low expected %h actual %h", $time,
					want.span_low, got.span_low);
				errors++;
			end
			if (got.span_high !== want.span_high) begin
				$display("%0t: span_high expected %h actual %h", $time,
					want.span_high, got.span_high);
				errors++;
			end
			if (got.next_seq !== want.next_seq) begin
				$display("%0t: next_seq expected %h actual %h", $time,
					want.next_seq, got.next_seq);
				errors++;
			end
			if (got.table_full !== want.table_full) begin
				$display("%0t: table_full expected %h actual %h", $time,
					want.table_full, got.table_full);
				errors++;
			end
		end
	endtask

	function automatic logic [31:0] any_seq();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'hFFFF_FFF0 + $urandom_range(0, 31);
			2: return 32'h7FFF_FFF0 + $urandom_range(0, 31);
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	// directed: field extremes, every opcode, wrap, full table, chain, unused codes
	task automatic test_directed();
		send_word(tsrt_pkg::OP_SPAN, 32'h0, 32'h0);
		send_word(tsrt_pkg::OP_COVERED, 32'hFFFF_FFFF, 32'h0);
		send_word(tsrt_pkg::OP_APPEND, 32'hFFFF_FFF0, 32'h0000_0010);
		send_word(tsrt_pkg::OP_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFF0);
		send_word(tsrt_pkg::OP_COVERED, 32'h0000_0005, 32'hFFFF_FFFF);
		send_word(tsrt_pkg::OP_TOTAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(tsrt_pkg::OP_OVERLAP, 32'hFFFF_FFF8, 32'h0000_0008);
		send_word(tsrt_pkg::OP_SPAN, 32'h8000_0000, 32'h0);
		send_word(tsrt_pkg::OP_CHAIN, 32'hFFFF_FF00, 32'h0);
		send_word(tsrt_pkg::OP_APPEND, 32'd100, 32'd200);
		send_word(tsrt_pkg::OP_APPEND, 32'd300, 32'd400);
		send_word(tsrt_pkg::OP_DELBEF, 32'd250, 32'h0);
		send_word(tsrt_pkg::OP_CLEAR, 32'h0, 32'h0);
		for (int k = 0; k < tsrt_pkg::DEPTH + 1; k++)
			send_word(k[0] ? tsrt_pkg::OP_INSERT : tsrt_pkg::OP_APPEND, 32'd10 * k,
				32'd10 * k + 10);
		send_word(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(4'd15, 32'h0, 32'h0);
		send_word(tsrt_pkg::OP_CHAIN, 32'd0, 32'h0);
	endtask

	// random: mostly contiguous segments with noise, so chains and inserts match
	task automatic test_random(int n);
		logic [31:0] base, len, a, b;
		logic [3:0]  op;
		base = any_seq();
		for (int k = 0; k < n; k++) begin
			len = $urandom_range(1, 40);
			case ($urandom_range(0, 19))
				0, 1, 2, 3: begin
					op = tsrt_pkg::OP_APPEND;
					a = base + $urandom_range(0, 6) * 20;
					b = a + len;
				end
				4, 5, 6: begin
					op = tsrt_pkg::OP_INSERT;
					b = base + $urandom_range(0, 6) * 20;
					a = b - len;
				end
				7: begin
					op = tsrt_pkg::OP_COVERED;
					a = base + $urandom_range(0, 150);
					b = $urandom();
				end
				8: begin op = tsrt_pkg::OP_TOTAL; a = $urandom(); b = $urandom(); end
				9: begin
					op = tsrt_pkg::OP_OVERLAP;
					a = base + $urandom_range(0, 80);
					b = a + $urandom_range(0, 100);
				end
				10: begin
					op = tsrt_pkg::OP_SPAN;
					a = base + $urandom_range(0, 150) - 30;
					b = $urandom();
				end
				11, 12: begin
					op = tsrt_pkg::OP_CHAIN;
					a = base + $urandom_range(0, 6) * 20;
					b = $urandom();
				end
				13: begin
					op = tsrt_pkg::OP_DELBEF;
					a = base + $urandom_range(0, 150);
					b = $urandom();
				end
				14: begin
					op = tsrt_pkg::OP_CLEAR;
					a = $urandom();
					b = $urandom();
					base = any_seq();
				end
				15: begin op = 4'($urandom_range(9, 15)); a = $urandom(); b = $urandom(); end
				default: begin op = 4'($urandom_range(0, 8)); a = any_seq(); b = any_seq(); end
			endcase
			send_word(op, a, b);
		end
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		hold_off = 300;
		test_random(40);
	endtask

	initial begin
		errors   = 0;
		hold_off = 0;
		tbl_cnt  = 0;
		arst_n   = 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.opcode <= tsrt_pkg::OP_CLEAR;
		in_ch.seq_a  <= '0;
		in_ch.seq_b  <= '0;
		repeat (6) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1500);
		in_ch.valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
rtl/core/tsrt_pkg.sv
rtl/core/tsrt_if.sv
rtl/core/tsrt_cell.sv
rtl/core/tcp_seq_range_table.sv
bench/tcp_seq_range_table_tb.sv
